@@ rtl/core/fsc_pkg.sv @@
// ----------------------------------------------------------------------------
// fsc_pkg
// Shared types and constants for the frustum sphere culler.
// ----------------------------------------------------------------------------
package fsc_pkg;

    localparam int WORD_WIDTH = 32;
    localparam int PB = (WORD_WIDTH > 32) ? 32 : ((WORD_WIDTH < 16) ? 16 : WORD_WIDTH);
    localparam int NPLANE = 6;
    localparam int NWORD = 24;
    localparam int AW = 5;

    localparam logic [0:0] ACT_LOAD = 1'b0;
    localparam logic [0:0] ACT_TEST = 1'b1;

    // Square-root engine handshake.
    typedef struct packed {
        logic        start;
        logic [63:0] radicand;
    } t_sqrt_req;

    typedef struct packed {
        logic        done;
        logic [32:0] root;
    } t_sqrt_rsp;

    function automatic logic signed [PB-1:0] sat_word(input logic signed [65:0] v);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        begin
            hi = (66'sd1 <<< (PB - 1)) - 66'sd1;
            lo = -hi - 66'sd1;
            if (v > hi) sat_word = hi[PB-1:0];
            else if (v < lo) sat_word = lo[PB-1:0];
            else sat_word = v[PB-1:0];
        end
    endfunction

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        begin
            s = {a[63], a} + {b[63], b};
            if (s[64] != s[63]) sat_add64 = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            else sat_add64 = s[63:0];
        end
    endfunction

endpackage

@@ rtl/core/frustum_sphere_culler_top.sv @@
// ----------------------------------------------------------------------------
// frustum_sphere_culler_top
// Frustum plane extraction from a matrix and sphere visibility test.
// ----------------------------------------------------------------------------
// A load item (tuser = 0) takes one matrix column and writes component
// 'column' of all six planes, one plane per cycle through one adder.
// Loading column 3 then normalizes every plane: it sums the squares of the
// plane's x, y and z, takes the square root and divides each of the four
// components by it (a zero-length plane skips the division); no result is
// returned. A test item (tuser = 1) runs, per plane, one multiply step
// (three multipliers) and then accumulate and compare steps, stops at the
// first plane that culls the sphere, and returns one visible item. A
// finished result moves into the output register; if that register is
// still full, the result waits inside the block and the input stalls
// until the receiver takes the older one. The block takes no new item
// while the current one is in progress.
// ----------------------------------------------------------------------------
module frustum_sphere_culler_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // column[1:0], entry_0..entry_3, center_x, center_y, center_z, radius[30:0], 7 pad
    input  logic [263:0] s_axis_tdata,
    // action
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // visible
    output logic [7:0]   m_axis_tdata
);
    import fsc_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b00000001,
        ST_LOAD  = 8'b00000010,
        ST_SQ    = 8'b00000100,
        ST_SQRT  = 8'b00001000,
        ST_DIV   = 8'b00010000,
        ST_MUL   = 8'b00100000,
        ST_ACC   = 8'b01000000,
        ST_OUT   = 8'b10000000
    } t_state;

    t_state r_state;
    logic signed [PB-1:0] r_pl [NWORD];
    logic [1:0]  r_col;
    logic signed [31:0] r_e [4];
    logic signed [31:0] r_c [3];
    logic [30:0] r_rad;
    logic [2:0]  r_p;
    logic [2:0]  r_k;
    logic [63:0] r_sum;
    logic [32:0] r_len;
    logic signed [63:0] r_prod [3];
    logic signed [63:0] r_d;
    logic        r_vis;
    logic        r_pend;
    logic        r_div_go;
    logic        r_out;

    t_sqrt_req w_sreq;
    t_sqrt_rsp w_srsp;
    logic        w_ddone;
    logic [47:0] w_quo;
    logic [47:0] w_qs_raw;
    logic [AW-1:0] w_idx;
    logic signed [PB-1:0] w_cur;
    logic [31:0] w_mag;
    logic [63:0] w_sq;
    logic [47:0] w_qs;
    logic signed [63:0] w_thr;
    logic signed [63:0] w_wt;
    logic        w_cull;
    logic        w_oload;
    logic        w_onext;

    assign w_idx = {r_p, r_k[1:0]};
    assign w_cur = r_pl[w_idx];
    assign w_mag = w_cur[PB-1] ? 32'(-{{(33-PB){w_cur[PB-1]}}, w_cur})
                               : 32'({{(33-PB){1'b0}}, w_cur});
    assign w_sq  = {32'd0, w_mag} * {32'd0, w_mag};
    assign w_qs  = (w_quo > 48'h80000000) ? 48'h80000000 : w_quo;
    assign w_thr = -($signed({33'd0, r_rad}) <<< 16);
    assign w_wt  = 64'(r_pl[{r_p, 2'd3}]) <<< 16;

    // Plane verdict in the last accumulate cycle of a plane.
    assign w_cull = (sat_add64(r_d, w_wt) < w_thr);

    // Output register loads a fresh verdict or the one waiting in ST_OUT.
    assign w_oload = ((r_state == ST_ACC) && (r_k == 3'd3) && (w_cull || (r_p == 3'd5))
                      && (!r_out || m_axis_tready))
                     || ((r_state == ST_OUT) && m_axis_tready);
    assign w_onext = (r_state == ST_OUT) ? r_pend : !w_cull;

    assign w_sreq.start    = (r_state == ST_SQ) && (r_k == 3'd3);
    assign w_sreq.radicand = r_sum;

    fsc_sqrt u_sqrt (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_sreq), .o_rsp(w_srsp));
    fsc_div  u_div  (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_div_go),
                     .i_mag(w_mag), .i_len(r_len), .o_done(w_ddone), .o_quo(w_qs_raw));

    assign w_quo = w_qs_raw;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out;
    assign m_axis_tdata  = {7'd0, r_vis};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_out      <= 1'b0;
            r_vis      <= 1'b0;
            r_div_go   <= 1'b0;
            for (int i = 0; i < NWORD; i++) r_pl[i] <= '0;
        end else begin
            r_div_go <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_col <= s_axis_tdata[1:0];
                        for (int i = 0; i < 4; i++) r_e[i] <= s_axis_tdata[2+32*i +: 32];
                        for (int i = 0; i < 3; i++) r_c[i] <= s_axis_tdata[130+32*i +: 32];
                        r_rad <= s_axis_tdata[226 +: 31];
                        r_p   <= 3'd0;
                        r_k   <= 3'd0;
                        r_d   <= 64'sd0;
                        r_state <= (s_axis_tuser == ACT_TEST) ? ST_MUL : ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    r_pl[{r_p, r_col}] <= sat_word(r_p[0]
                        ? (66'(r_e[3]) - 66'(r_e[r_p[2:1]]))
                        : (66'(r_e[3]) + 66'(r_e[r_p[2:1]])));
                    if (r_p == 3'd5) begin
                        r_p <= 3'd0;
                        r_k <= 3'd0;
                        r_sum <= 64'd0;
                        r_state <= (r_col == 2'd3) ? ST_SQ : ST_IDLE;
                    end else begin
                        r_p <= r_p + 3'd1;
                    end
                end
                ST_SQ: begin
                    if (r_k == 3'd3) begin
                        r_state <= ST_SQRT;
                    end else begin
                        r_sum <= r_sum + w_sq;
                        r_k   <= r_k + 3'd1;
                    end
                end
                ST_SQRT: begin
                    if (w_srsp.done) begin
                        r_len <= w_srsp.root;
                        r_k   <= 3'd0;
                        if (w_srsp.root == 33'd0) begin
                            if (r_p == 3'd5) r_state <= ST_IDLE;
                            else begin
                                r_p <= r_p + 3'd1;
                                r_sum <= 64'd0;
                                r_state <= ST_SQ;
                            end
                        end else begin
                            r_div_go <= 1'b1;
                            r_state <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    if (w_ddone) begin
                        r_pl[w_idx] <= sat_word(w_cur[PB-1] ? -$signed({18'd0, w_qs})
                                                            : $signed({18'd0, w_qs}));
                        if (r_k == 3'd3) begin
                            r_k <= 3'd0;
                            if (r_p == 3'd5) r_state <= ST_IDLE;
                            else begin
                                r_p <= r_p + 3'd1;
                                r_sum <= 64'd0;
                                r_state <= ST_SQ;
                            end
                        end else begin
                            r_k <= r_k + 3'd1;
                            r_div_go <= 1'b1;
                        end
                    end
                end
                ST_MUL: begin
                    for (int i = 0; i < 3; i++)
                        r_prod[i] <= 64'(r_pl[{r_p, 2'(i)}]) * 64'(r_c[i]);
                    r_state <= ST_ACC;
                    r_k <= 3'd0;
                    r_d <= 64'sd0;
                end
                ST_ACC: begin
                    if (r_k == 3'd3) begin
                        if (w_cull || (r_p == 3'd5)) begin
                            // Park the verdict while the output register is busy.
                            r_pend  <= !w_cull;
                            r_state <= (!r_out || m_axis_tready) ? ST_IDLE : ST_OUT;
                        end else begin
                            r_p <= r_p + 3'd1;
                            r_state <= ST_MUL;
                        end
                    end else begin
                        r_d <= sat_add64(r_d, r_prod[r_k[1:0]]);
                        r_k <= r_k + 3'd1;
                    end
                end
                ST_OUT: begin
                    if (m_axis_tready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase

            if (w_oload) begin
                r_out <= 1'b1;
                r_vis <= w_onext;
            end else if (m_axis_tready) begin
                r_out <= 1'b0;
            end
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result dropped or changed while stalled");
    a_pend_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |-> m_axis_tvalid) else $error("parked result with empty output");
    a_div_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_go |-> (r_state == ST_DIV)) else $error("divide outside divide state");
    a_len_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_len != 33'd0)) else $error("divide by zero length");

endmodule

@@ rtl/core/fsc_sqrt.sv @@
// ----------------------------------------------------------------------------
// fsc_sqrt
// Bit-pair iterative integer square root of a 64-bit radicand, 32 steps.
// ----------------------------------------------------------------------------
module fsc_sqrt (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fsc_pkg::t_sqrt_req i_req,
    output fsc_pkg::t_sqrt_rsp o_rsp
);
    import fsc_pkg::*;

    logic [63:0] r_rem;
    logic [63:0] r_res;
    logic [63:0] r_bit;
    logic        r_busy;
    logic        r_done;
    logic [63:0] n_trial;

    assign n_trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_rem  <= i_req.radicand;
                r_res  <= 64'd0;
                r_bit  <= 64'd1 << 62;
            end else if (r_busy) begin
                if (r_rem >= n_trial) begin
                    r_rem <= r_rem - n_trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_bit[0]) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.root = r_res[32:0];

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("sqrt done held");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> $past(r_busy)) else $error("sqrt done without work");
    a_idle_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("sqrt busy at done");

endmodule

@@ rtl/core/fsc_div.sv @@
// ----------------------------------------------------------------------------
// fsc_div
// Restoring divider: (mag << 16) / len, one quotient bit per cycle, 48 steps.
// ----------------------------------------------------------------------------
module fsc_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_mag,
    input  logic [32:0] i_len,
    output logic        o_done,
    output logic [47:0] o_quo
);
    import fsc_pkg::*;

    logic [47:0] r_num;
    logic [33:0] r_rem;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [33:0] n_sh;

    assign n_sh = {r_rem[32:0], r_num[47]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_num  <= {i_mag, 16'd0};
                r_rem  <= 34'd0;
                r_cnt  <= 6'd47;
            end else if (r_busy) begin
                if (n_sh >= {1'b0, i_len}) begin
                    r_rem <= n_sh - {1'b0, i_len};
                    r_num <= {r_num[46:0], 1'b1};
                end else begin
                    r_rem <= n_sh;
                    r_num <= {r_num[46:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num;

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("div done held");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> $past(r_busy)) else $error("div done without work");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_start && i_len != 33'd0) |-> (r_rem < {1'b0, i_len}))
        else $error("div remainder out of range");

endmodule

@@ dv/frustum_sphere_culler_top_tb.sv @@
// ----------------------------------------------------------------------------
// frustum_sphere_culler_top_tb
// Self-checking bench for the frustum plane extraction and sphere culler.
// ----------------------------------------------------------------------------
// Matrix columns and sphere tests are driven on the slave stream, and every
// visible item on the master stream is checked against a local plane model
// kept in step with each accepted item. A short directed table comes first,
// then random matrix reloads with bursts of sphere tests. Both sides idle at
// random, one window runs without gaps, and the receiver stalls once for a
// long stretch so the block backs up onto its input.
// ----------------------------------------------------------------------------
module frustum_sphere_culler_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fsc_pkg::*;

    localparam int RAND_ITEMS = 730;
    localparam int IDLE_LIMIT = 8000;
    localparam int DRAIN_WAIT = 2500;
    localparam int HOLD_LEN   = 300;

    // One slave item; want < 0 means the plane model decides.
    typedef struct packed {
        logic              act;
        logic [1:0]        col;
        logic [3:0][31:0]  ent;
        logic [2:0][31:0]  ctr;
        logic [30:0]       rad;
        int                want;
    } t_sphere_item;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [263:0] s_axis_tdata;   // column, entry_0..3, center_x/y/z, radius, pad
    logic         s_axis_tuser;   // action
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [7:0]   m_axis_tdata;   // visible

    frustum_sphere_culler_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Plane model: 6 planes x (x, y, z, w), saturated to the plane word.
    // ------------------------------------------------------------------------
    logic signed [31:0] planes [24];
    logic               vis_queue [$];
    t_sphere_item       cur_item;
    t_sphere_item       table_rows [$];

    int  errors     = 0;
    int  n_tests    = 0;
    int  n_loads    = 0;
    int  n_visible  = 0;
    int  n_culled   = 0;
    bit  calm       = 1'b0;   // no idling on either side while set
    bit  hold_go    = 1'b0;

    function automatic logic signed [31:0] clamp_word(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        if (v < -66'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [63:0] acc_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s[63:0];
    endfunction

    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bt;
        res = 64'd0;
        bt  = 64'd1 << 62;
        while (bt > v) bt = bt >> 2;
        while (bt != 64'd0) begin
            if (v >= res + bt) begin
                v   = v - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] magn(input logic signed [31:0] v);
        logic signed [63:0] w;
        w = v;
        return (w < 0) ? -w : w;
    endfunction

    // Scale every non-degenerate plane by 1 / |normal|.
    task automatic renormalize_planes();
        logic [63:0]        sum;
        logic [63:0]        len;
        logic [63:0]        q;
        logic signed [65:0] s;
        for (int p = 0; p < 6; p++) begin
            sum = 64'd0;
            for (int k = 0; k < 3; k++) sum = sum + magn(planes[4*p+k]) * magn(planes[4*p+k]);
            len = root_floor(sum);
            if (len != 64'd0) begin
                for (int k = 0; k < 4; k++) begin
                    q = (magn(planes[4*p+k]) << 16) / len;
                    if (q > 64'h80000000) q = 64'h80000000;
                    s = {2'b00, q};
                    if (planes[4*p+k] < 0) s = -s;
                    planes[4*p+k] = clamp_word(s);
                end
            end
        end
    endtask

    task automatic apply_item(input t_sphere_item it);
        logic signed [65:0] e3;
        logic signed [65:0] ep;
        logic signed [63:0] d;
        logic signed [63:0] thr;
        logic signed [63:0] cv;
        logic               vis;
        if (it.act == ACT_LOAD) begin
            n_loads++;
            e3 = $signed(it.ent[3]);
            for (int p = 0; p < 6; p++) begin
                ep = $signed(it.ent[p >> 1]);
                planes[4*p + it.col] = clamp_word((p % 2) ? e3 - ep : e3 + ep);
            end
            if (it.col == 2'd3) renormalize_planes();
        end else begin
            n_tests++;
            thr = -($signed({33'd0, it.rad}) <<< 16);
            vis = 1'b1;
            for (int p = 0; p < 6 && vis; p++) begin
                d = 64'sd0;
                for (int k = 0; k < 3; k++) begin
                    cv = $signed(it.ctr[k]);
                    d  = acc_add(d, 64'(planes[4*p+k]) * cv);
                end
                d = acc_add(d, 64'(planes[4*p+3]) <<< 16);
                if (d < thr) vis = 1'b0;
            end
            if (it.want >= 0) vis = it.want[0];
            vis_queue.insert(vis_queue.size(), vis);
        end
    endtask

    // Input acceptance feeds the model; output acceptance checks against it.
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) apply_item(cur_item);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (vis_queue.size() == 0) begin
                $display("%0t: unexpected visible item, actual %0d", $time, m_axis_tdata[0]);
                errors++;
            end else begin
                if (m_axis_tdata[0] !== vis_queue[0]) begin
                    $display("%0t: visible mismatch, expected %0d actual %0d",
                             $time, vis_queue[0], m_axis_tdata[0]);
                    errors++;
                end
                if (vis_queue[0]) n_visible++;
                else n_culled++;
                void'(vis_queue.pop_front());
            end
        end
    end

    // Watchdog on cycles with no item moving on either side.
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: watchdog, no traffic for %0d cycles", $time, IDLE_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off once hold_go rises.
    initial begin
        bit held;
        held = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_go && !held) begin
                held = 1'b1;
                m_axis_tready = 1'b0;
                repeat (HOLD_LEN) @(negedge i_clk);
            end
            m_axis_tready = calm ? 1'b1 : ($urandom_range(99) >= 33);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [31:0] rand_q();
        case ($urandom_range(4))
            0:       return $urandom;
            1:       return 32'($signed($urandom_range(524288)) - 262144);   // +-4.0
            2:       return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            3:       return $urandom_range(1) ? 32'h00010000 : 32'hffff0000;  // +-1.0
            default: return 32'($signed($urandom_range(131072)) - 65536);    // +-1.0
        endcase
    endfunction

    function automatic t_sphere_item rand_item(input logic act, input logic [1:0] col);
        t_sphere_item it;
        it.act  = act;
        it.col  = col;
        it.want = -1;
        for (int k = 0; k < 4; k++) it.ent[k] = rand_q();
        for (int k = 0; k < 3; k++) it.ctr[k] = rand_q();
        case ($urandom_range(3))
            0:       it.rad = 31'($urandom);
            1:       it.rad = $urandom_range(1) ? 31'h7fffffff : 31'd0;
            default: it.rad = 31'($urandom_range(196608));
        endcase
        return it;
    endfunction

    function automatic t_sphere_item row(input logic act, input logic [1:0] col,
                                         input logic [31:0] e0, e1, e2, e3,
                                         input logic [31:0] cx, cy, cz,
                                         input logic [30:0] r, input int want);
        t_sphere_item it;
        it.act = act;
        it.col = col;
        it.ent = {e3, e2, e1, e0};
        it.ctr = {cz, cy, cx};
        it.rad = r;
        it.want = want;
        return it;
    endfunction

    task automatic add_row(input t_sphere_item it);
        table_rows = {table_rows, it};
    endtask

    // Valid stays high across back-to-back items; data changes on the falling edge.
    task automatic send_item(input t_sphere_item it);
        if (!calm && $urandom_range(99) < 33) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        cur_item      = it;
        s_axis_tdata  = {7'd0, it.rad, it.ctr[2], it.ctr[1], it.ctr[0],
                         it.ent[3], it.ent[2], it.ent[1], it.ent[0], it.col};
        s_axis_tuser  = it.act;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    localparam logic [31:0] ONE  = 32'h00010000;
    localparam logic [31:0] MAXQ = 32'h7fffffff;
    localparam logic [31:0] MINQ = 32'h80000000;
    localparam logic [30:0] RMAX = 31'h7fffffff;

    initial begin
        int sent;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACT_LOAD;
        cur_item      = '0;
        i_rst_n       = 1'b0;
        for (int i = 0; i < 24; i++) planes[i] = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table: empty planes, degenerate planes, unit frustum,
        // saturating sums, and columns loaded out of order.
        add_row(row(ACT_TEST, 0, 0, 0, 0, 0, MAXQ, MINQ, MAXQ, 0, 1));
        add_row(row(ACT_TEST, 3, MAXQ, MAXQ, MAXQ, MAXQ, MINQ, MINQ, MINQ, RMAX, 1));
        for (int c = 0; c < 4; c++)
            add_row(row(ACT_LOAD, 2'(c), 0, 0, 0, 0, MAXQ, MAXQ, MAXQ, RMAX, -1));
        add_row(row(ACT_TEST, 0, 0, 0, 0, 0, ONE, ONE, ONE, 0, 1));
        add_row(row(ACT_LOAD, 3, 0, 0, 0, ONE, 0, 0, 0, 0, -1));
        add_row(row(ACT_TEST, 0, 0, 0, 0, 0, MINQ, MAXQ, MINQ, 0, -1));
        add_row(row(ACT_LOAD, 0, ONE, 0, 0, 0, 0, 0, 0, 0, -1));
        add_row(row(ACT_LOAD, 1, 0, ONE, 0, 0, 0, 0, 0, 0, -1));
        add_row(row(ACT_LOAD, 2, 0, 0, ONE, 0, 0, 0, 0, 0, -1));
        add_row(row(ACT_LOAD, 3, 0, 0, 0, ONE, 0, 0, 0, 0, -1));
        add_row(row(ACT_TEST, 0, 0, 0, 0, 0, 0, 0, 0, 0, -1));
        add_row(row(ACT_TEST, 0, 0, 0, 0, 0, 32'h00050000, 0, 0, 0, -1));
        add_row(row(ACT_TEST, 0, 0, 0, 0, 0, 32'h00050000, 0, 0, 31'h00050000, -1));
        add_row(row(ACT_TEST, 0, 0, 0, 0, 0, 0, 32'hfffd0000, 0, 31'h00010000, -1));
        add_row(row(ACT_LOAD, 0, MAXQ, MINQ, MAXQ, MAXQ, 0, 0, 0, 0, -1));
        add_row(row(ACT_LOAD, 1, MINQ, MAXQ, MINQ, MINQ, 0, 0, 0, 0, -1));
        add_row(row(ACT_LOAD, 2, MAXQ, MAXQ, MINQ, 0, 0, 0, 0, 0, -1));
        add_row(row(ACT_LOAD, 3, MINQ, MAXQ, 0, MAXQ, 0, 0, 0, 0, -1));
        add_row(row(ACT_TEST, 0, 0, 0, 0, 0, MAXQ, MINQ, MAXQ, 0, -1));
        add_row(row(ACT_LOAD, 1, ONE, 32'hffff0000, 0, 32'h00020000, 0, 0, 0, 0, -1));
        add_row(row(ACT_TEST, 0, 0, 0, 0, 0, 0, MINQ, 0, 0, -1));
        add_row(row(ACT_TEST, 0, 0, 0, 0, 0, MINQ, 0, MAXQ, RMAX, -1));
        foreach (table_rows[i]) send_item(table_rows[i]);

        // Random part: mostly full matrix reloads followed by bursts of tests.
        sent = 0;
        while (sent < RAND_ITEMS) begin
            if (sent == 400) calm = 1'b1;
            if (sent == 490) calm = 1'b0;
            if (n_tests >= 150) hold_go = 1'b1;
            if ($urandom_range(49) == 0) begin
                if ($urandom_range(9) != 0) begin
                    for (int c = 0; c < 4; c++) send_item(rand_item(ACT_LOAD, 2'(c)));
                    sent += 4;
                end else begin
                    send_item(rand_item(ACT_LOAD, 2'($urandom_range(3))));
                    sent++;
                end
            end else begin
                send_item(rand_item(ACT_TEST, 2'($urandom_range(3))));
                sent++;
            end
        end
        s_axis_tvalid = 1'b0;

        while (vis_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (vis_queue.size() != 0) begin
            $display("%0t: %0d visible items never arrived", $time, vis_queue.size());
            errors++;
        end

        $display("run: %0d column loads, %0d sphere tests (%0d visible, %0d culled)",
                 n_loads, n_tests, n_visible, n_culled);
        $display("run: one long output stall, one gap-free window, %0d mismatches", errors);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
